@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/tap_pkg.sv @@
`timescale 1ns / 1ps
package tap_pkg;
  localparam int unsigned CfgWidth = 48;
  localparam int unsigned CfgIdxWidth = 3;
  // Angles, errors and the integral carry this many fractional bits of a degree.
  localparam int unsigned AngleFracBits = 6;

  typedef enum logic [2:0] {
    REG_GAINS_PITCH = 3'd0,
    REG_GAINS_ROLL  = 3'd1,
    REG_GAINS_YAW   = 3'd2,
    REG_ENABLE      = 3'd3,
    REG_COLL_TRIM   = 3'd4,
    REG_STEP_PERIOD = 3'd5,
    REG_STEP_RATE   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] meas_yaw;
    logic signed [15:0] meas_pitch;
    logic signed [15:0] meas_roll;
    logic [7:0]         stick_collective;
    logic [7:0]         stick_yaw;
    logic [7:0]         stick_pitch;
    logic [7:0]         stick_roll;
    logic signed [15:0] applied_yaw;
    logic signed [15:0] applied_pitch;
    logic signed [15:0] applied_roll;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0]  drive_collective;
    logic signed [15:0] drive_yaw;
    logic signed [15:0] drive_pitch;
    logic signed [15:0] drive_roll;
  } out_item_t;
endpackage

@@ sv/tap_if.sv @@
`timescale 1ns / 1ps
interface tap_in_if;
  import tap_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tap_out_if;
  import tap_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/three_axis_attitude_pid.sv @@
`timescale 1ns / 1ps
// Three-axis attitude PID with collective pass-through.
// Input channel in_if carries one control tick: three measured angles (Q.F degrees),
// four raw stick bytes and the three servo values applied after the previous tick.
// Output channel out_if carries one item per tick while enabled: collective minus trim
// and the saturated yaw, pitch and roll drives. Gains, enable, trim, dt and 1/dt are set
// through the write port (cfg_we_i, cfg_idx_i, cfg_data_i). The user must write them
// only while the block is idle; the block itself does not enforce this. A tick runs
// from acceptance to the presented result through a setup step, then seven steps per
// axis through a single shared 40x18 signed multiplier, one adder and a rounding stage,
// the last of which loads the result register. With the receiver ready a new tick is
// accepted once the result has been taken. While disabled a tick is absorbed with no
// result and no state change.
// Reset clears the integrators, previous errors and last drives and loads the default
// register values. If the receiver stalls, the result holds in the output register and
// in_if.ready stays low until it is taken.
`include "assert_macros.svh"
module three_axis_attitude_pid (
  input  logic clk_i,
  input  logic rst_ni,
  tap_in_if.sink    in_if,
  tap_out_if.source out_if,
  input  logic                          cfg_we_i,
  input  logic [tap_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [tap_pkg::CfgWidth-1:0]    cfg_data_i
);
  import tap_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_INC, S_PTERM, S_ITERM, S_DMUL, S_DTERM, S_ROUND, S_DONE
  } state_e;
  typedef enum logic [1:0] {AX_YAW = 2'd0, AX_PITCH = 2'd1, AX_ROLL = 2'd2} axis_e;

  localparam int unsigned DenConst = 100 << AngleFracBits;
  localparam logic signed [63:0] HalfDen = 64'(DenConst / 2);
  localparam logic [63:0] SatMag = 64'(DenConst) * 64'd32768;
  localparam logic signed [17:0] RollOff = 18'(6 << AngleFracBits);
  localparam logic [19:0] Recip5 = 20'd838861;
  localparam logic [23:0] Recip25 = 24'd10737419;
  localparam logic [21:0] YawScale = 22'(9 << AngleFracBits);
  localparam logic [21:0] TiltScale = 22'(3 << (AngleFracBits - 1));

  logic [47:0] gains_q [3];
  logic        enable_q;
  logic [7:0]  trim_q;
  logic [15:0] period_q, rate_q;

  logic signed [31:0] integ_q [3];
  logic signed [31:0] pinteg_q [3];
  logic signed [17:0] perr_q [3];
  logic signed [15:0] last_q [3];

  state_e state_q;
  axis_e  ax_q;
  in_item_t item_q;
  logic signed [17:0] err_q;
  logic signed [31:0] ival_q;
  logic signed [63:0] acc_q;
  logic signed [39:0] dprod_q;
  logic signed [17:0] sp_q [3];
  logic               ovalid_q;
  out_item_t          odata_q;

  // Setpoints: stick offset times k*2^F, rounded half away from zero. Both scales come
  // down to a division by five, done as a reciprocal multiplication exact below 2^22.
  function automatic logic signed [17:0] set_pt(input logic signed [8:0] d, input logic yaw);
    logic [8:0]  mag;
    logic [21:0] n;
    logic [41:0] p;
    logic [17:0] q;
    begin
      mag = d[8] ? 9'(-d) : 9'(d);
      n = 22'(mag) * (yaw ? YawScale : TiltScale);
      p = 42'(n + 22'd2) * 42'(Recip5);
      q = p[39:22];
      set_pt = d[8] ? -$signed(q) : $signed(q);
    end
  endfunction

  // Shared multiplier operands.
  logic signed [39:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [63:0] mul_p;
  logic [47:0] g;
  logic signed [18:0] esum, ediff;
  logic signed [31:0] ibase;
  logic signed [15:0] applied, meas;
  logic signed [18:0] err_full;
  logic signed [17:0] err_sat;

  always_comb begin
    g = gains_q[ax_q];
    case (ax_q)
      AX_YAW:   begin applied = item_q.applied_yaw;   meas = item_q.meas_yaw;   end
      AX_PITCH: begin applied = item_q.applied_pitch; meas = item_q.meas_pitch; end
      default:  begin applied = item_q.applied_roll;  meas = item_q.meas_roll;  end
    endcase
    err_full = 19'(sp_q[ax_q]) - 19'(meas) - ((ax_q == AX_ROLL) ? 19'(RollOff) : 19'sd0);
    if (err_full > 19'sd131071)       err_sat = 18'sd131071;
    else if (err_full < -19'sd131072) err_sat = -18'sd131072;
    else                              err_sat = err_full[17:0];
    ibase = (applied != last_q[ax_q]) ? pinteg_q[ax_q] : integ_q[ax_q];
    esum  = 19'(err_q) + 19'(perr_q[ax_q]);
    ediff = 19'(err_q) - 19'(perr_q[ax_q]);
    case (state_q)
      S_INC:   begin mul_a = 40'($signed({1'b0, period_q})); mul_b = esum[18:1]; end
      S_PTERM: begin mul_a = 40'($signed({1'b0, g[15:0]}));  mul_b = err_q; end
      S_ITERM: begin mul_a = 40'(ival_q); mul_b = 18'($signed({1'b0, g[31:16]})); end
      S_DMUL:  begin mul_a = 40'($signed({1'b0, g[47:32]})); mul_b = 18'(ediff); end
      S_DTERM: begin mul_a = dprod_q; mul_b = 18'($signed({1'b0, rate_q})); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Increment uses the full 19-bit sum; low bit is handled separately.
  logic signed [63:0] inc_prod, inc_num, inc_v;
  logic signed [32:0] isum;
  logic signed [31:0] isat;
  logic signed [63:0] rnd_v;
  logic [63:0] rnd_mag;
  logic        rnd_big;
  logic [19:0] rnd_x;
  logic [43:0] rnd_p;
  logic [15:0] rnd_q;
  logic signed [15:0] drv, drv_neg;
  always_comb begin
    inc_prod = (mul_p <<< 1) + (esum[0] ? 64'($signed({1'b0, period_q})) : 64'sd0);
    inc_num  = inc_prod + 64'sd65536;
    inc_v    = inc_num >>> 17;
    isum = 33'(ibase) + 33'(inc_v);
    if (isum > 33'sd2147483647)       isat = 32'h7fffffff;
    else if (isum < -33'sd2147483648) isat = 32'h80000000;
    else                              isat = isum[31:0];
    // The divisor is 25 times a power of two. Below the saturation bound the shifted
    // magnitude fits in 20 bits, where the reciprocal of 25 is exact.
    rnd_v   = acc_q + HalfDen;
    rnd_mag = rnd_v[63] ? 64'(-rnd_v) : 64'(rnd_v);
    rnd_big = rnd_mag >= SatMag;
    rnd_x   = 20'(rnd_mag >> (AngleFracBits + 2));
    rnd_p   = 44'(rnd_x) * 44'(Recip25);
    rnd_q   = rnd_p[43:28];
    if (rnd_v[63]) drv = rnd_big ? 16'sh8000 : -$signed(rnd_q);
    else           drv = rnd_big ? 16'sh7fff : $signed(rnd_q);
    drv_neg = (drv == 16'sh8000) ? 16'sh7fff : -drv;
  end

  assign in_if.ready  = (state_q == S_IDLE) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q[0] <= 48'd1573164;
      gains_q[1] <= 48'd10944812;
      gains_q[2] <= 48'd10944812;
      enable_q <= 1'b1;
      trim_q   <= '0;
      period_q <= 16'd655;
      rate_q   <= 16'd100;
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= '0; pinteg_q[i] <= '0; perr_q[i] <= '0; last_q[i] <= '0;
      end
      state_q  <= S_IDLE;
      ax_q     <= AX_YAW;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_GAINS_YAW:   gains_q[0] <= cfg_data_i;
          REG_GAINS_PITCH: gains_q[1] <= cfg_data_i;
          REG_GAINS_ROLL:  gains_q[2] <= cfg_data_i;
          REG_ENABLE:      enable_q <= cfg_data_i[0];
          REG_COLL_TRIM:   trim_q <= cfg_data_i[7:0];
          REG_STEP_PERIOD: period_q <= cfg_data_i[15:0];
          REG_STEP_RATE:   rate_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ovalid_q && out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready && enable_q) begin
          item_q  <= in_if.data;
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          sp_q[0] <= -set_pt(9'($signed({1'b0, item_q.stick_yaw})) - 9'sd100, 1'b1);
          sp_q[1] <= set_pt(9'($signed({1'b0, item_q.stick_pitch})) - 9'sd50, 1'b0);
          sp_q[2] <= set_pt(9'($signed({1'b0, item_q.stick_roll})) - 9'sd50, 1'b0);
          odata_q.drive_collective <= 9'($signed({1'b0, item_q.stick_collective}))
                                      - 9'($signed({1'b0, trim_q}));
          ax_q    <= AX_YAW;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Entry of an axis: latch the saturated error.
          err_q   <= err_sat;
          state_q <= S_INC;
        end
        S_INC: begin
          pinteg_q[ax_q] <= ibase;
          integ_q[ax_q]  <= isat;
          ival_q  <= isat;
          state_q <= S_PTERM;
        end
        S_PTERM: begin acc_q <= mul_p; state_q <= S_ITERM; end
        S_ITERM: begin acc_q <= acc_q + mul_p; state_q <= S_DMUL; end
        S_DMUL:  begin dprod_q <= mul_p[39:0]; state_q <= S_DTERM; end
        S_DTERM: begin acc_q <= acc_q + mul_p; state_q <= S_ROUND; end
        S_ROUND: begin
          perr_q[ax_q] <= err_q;
          case (ax_q)
            AX_YAW: begin
              last_q[0] <= drv_neg; odata_q.drive_yaw <= drv_neg;
              ax_q <= AX_PITCH; state_q <= S_DONE;
            end
            AX_PITCH: begin
              last_q[1] <= drv; odata_q.drive_pitch <= drv;
              ax_q <= AX_ROLL; state_q <= S_DONE;
            end
            default: begin
              last_q[2] <= drv; odata_q.drive_roll <= drv;
              ovalid_q <= 1'b1; state_q <= S_IDLE;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_ready_busy, state_q != S_IDLE, !in_if.ready)
  `ASSERT_IMPL(a_no_ready_full, ovalid_q, !in_if.ready)
  `ASSERT_NEXT(a_done_sets_valid, state_q == S_ROUND && ax_q == AX_ROLL, ovalid_q)
  `ASSERT_NEXT(a_disabled_absorbs, in_if.valid && in_if.ready && !enable_q,
               state_q == S_IDLE)
endmodule

@@ bench/tb_three_axis_attitude_pid.sv @@
`timescale 1ns / 1ps
module tb_three_axis_attitude_pid;
  import tap_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  tap_in_if in_ch ();
  tap_out_if out_ch ();

  three_axis_attitude_pid uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Controller model: configuration and per-axis state (0 yaw, 1 pitch, 2 roll).
  logic [47:0] gains [3];
  logic        loop_on;
  logic [7:0]  trim_val;
  logic [15:0] dt_q16;
  logic [15:0] rate_hz;
  longint      integ [3];
  longint      integ_prev [3];
  longint      err_prev [3];
  longint      drive_last [3];

  out_item_t   drive_q [$];
  int          errors = 0;
  bit          idling = 1'b1;
  int          hold_cycles = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Scaled stick setpoint, rounded half away from zero.
  function automatic longint stick_angle(longint d, longint mul, longint dv);
    longint num;
    num = d * mul * 64;
    if (num >= 0) return (num + dv / 2) / dv;
    return -((-num + dv / 2) / dv);
  endfunction

  function automatic longint axis_pid(int ax, longint sp, longint meas, longint applied,
                                      logic [47:0] g);
    longint kp, ki, kd, e, pe, inc, sum, p, r;
    kp = g[15:0];
    ki = g[31:16];
    kd = g[47:32];
    p = dt_q16;
    r = rate_hz;
    if (applied != drive_last[ax]) integ[ax] = integ_prev[ax];
    e = clampl(sp - meas, -131072, 131071);
    pe = err_prev[ax];
    inc = (p * (e + pe) + 65536) >>> 17;
    integ_prev[ax] = integ[ax];
    integ[ax] = clampl(integ[ax] + inc, -64'sd2147483648, 64'sd2147483647);
    sum = kp * e + ki * integ[ax] + kd * (e - pe) * r;
    err_prev[ax] = e;
    return clampl((sum + 3200) / 6400, -32768, 32767);
  endfunction

  function automatic bit tick_drive(in_item_t d, output out_item_t res);
    longint dy, dp, dr, coll;
    res = '0;
    if (!loop_on) return 1'b0;
    dy = axis_pid(0, -stick_angle(longint'(d.stick_yaw) - 100, 9, 5),
                  longint'($signed(d.meas_yaw)), longint'($signed(d.applied_yaw)), gains[0]);
    dy = clampl(-dy, -32768, 32767);
    drive_last[0] = dy;
    dp = axis_pid(1, stick_angle(longint'(d.stick_pitch) - 50, 3, 10),
                  longint'($signed(d.meas_pitch)), longint'($signed(d.applied_pitch)),
                  gains[1]);
    drive_last[1] = dp;
    dr = axis_pid(2, stick_angle(longint'(d.stick_roll) - 50, 3, 10),
                  longint'($signed(d.meas_roll)) + 384, longint'($signed(d.applied_roll)),
                  gains[2]);
    drive_last[2] = dr;
    coll = longint'(d.stick_collective) - longint'(trim_val);
    res.drive_collective = coll[8:0];
    res.drive_yaw = dy[15:0];
    res.drive_pitch = dp[15:0];
    res.drive_roll = dr[15:0];
    return 1'b1;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Prediction on every accepted item, checking on every accepted result.
  always @(posedge clk_i) begin
    out_item_t res, want;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (tick_drive(in_ch.data, res)) drive_q.push_back(res);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      res = out_ch.data;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, res);
        errors++;
      end else begin
        want = drive_q.pop_front();
        check_field("drive_collective", want.drive_collective, res.drive_collective);
        check_field("drive_yaw", want.drive_yaw, res.drive_yaw);
        check_field("drive_pitch", want.drive_pitch, res.drive_pitch);
        check_field("drive_roll", want.drive_roll, res.drive_roll);
      end
    end
  end

  // Receiver: random stall bursts, or a long hold when one is requested.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_tick(in_item_t d);
    if (idling && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (drive_q.size() == 0);
    // A disabled tick leaves nothing to wait for, so allow a full tick time as well.
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GAINS_PITCH: gains[1] = val[47:0];
      REG_GAINS_ROLL:  gains[2] = val[47:0];
      REG_GAINS_YAW:   gains[0] = val[47:0];
      REG_ENABLE:      loop_on = val[0];
      REG_COLL_TRIM:   trim_val = val[7:0];
      REG_STEP_PERIOD: dt_q16 = val[15:0];
      REG_STEP_RATE:   rate_hz = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 4000)) - 2000);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_applied(int ax);
    if ($urandom_range(0, 9) < 8) return drive_last[ax][15:0];
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_tick();
    in_item_t d;
    d.meas_yaw = pick_angle();
    d.meas_pitch = pick_angle();
    d.meas_roll = pick_angle();
    d.stick_collective = 8'($urandom);
    d.stick_yaw = 8'($urandom);
    d.stick_pitch = 8'($urandom);
    d.stick_roll = 8'($urandom);
    d.applied_yaw = pick_applied(0);
    d.applied_pitch = pick_applied(1);
    d.applied_roll = pick_applied(2);
    return d;
  endfunction

  function automatic in_item_t fill_tick(logic [15:0] m, logic [7:0] s, logic [15:0] a);
    return '{m, m, m, s, s, s, s, a, a, a};
  endfunction

  task automatic test_defaults();
    // First tick after reset with nonzero applied values, then field extremes.
    send_tick(fill_tick(16'sd100, 8'd50, 16'sd77));
    send_tick(fill_tick(16'h7fff, 8'hff, 16'h7fff));
    send_tick(fill_tick(16'h8000, 8'h00, 16'h8000));
    send_tick(fill_tick(16'h0000, 8'd100, 16'h0000));
    send_tick(random_tick());
  endtask

  task automatic test_yaw_saturation();
    write_reg(REG_GAINS_YAW, 48'h0000_0000_ffff);
    write_reg(REG_COLL_TRIM, 48'd255);
    send_tick(fill_tick(16'h7fff, 8'd100, 16'h0000));
    send_tick(fill_tick(16'h8000, 8'd100, 16'h7fff));
    send_tick(fill_tick(16'h7fff, 8'd0, 16'h8000));
  endtask

  task automatic test_zero_step();
    write_reg(REG_STEP_PERIOD, 48'd0);
    write_reg(REG_STEP_RATE, 48'd0);
    write_reg(REG_GAINS_PITCH, 48'hffff_ffff_ffff);
    repeat (4) send_tick(random_tick());
  endtask

  task automatic test_disable();
    write_reg(REG_ENABLE, 48'd0);
    repeat (4) send_tick(random_tick());
    // An index past the register list must change nothing.
    write_reg(3'd7, 48'hffff_ffff_ffff);
    write_reg(REG_ENABLE, 48'd1);
    repeat (3) send_tick(random_tick());
  endtask

  task automatic test_random_phases();
    logic [47:0] g_set [4];
    logic [15:0] t_set [4];
    g_set = '{48'd0, 48'hffff_ffff_ffff, 48'd10944812, 48'd1573164};
    t_set = '{16'd1, 16'hffff, 16'd655, 16'd100};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) idling = 1'b0;
      write_reg(REG_GAINS_PITCH, ph < 4 ? g_set[ph] : 48'($urandom) << 16 | 48'($urandom));
      write_reg(REG_GAINS_ROLL, ph < 4 ? g_set[3 - ph] : 48'($urandom) << 16 | 48'($urandom));
      write_reg(REG_GAINS_YAW, ph < 4 ? g_set[(ph + 1) % 4] : 48'($urandom));
      write_reg(REG_COLL_TRIM, ph[0] ? 48'd255 : 48'($urandom_range(0, 255)));
      write_reg(REG_STEP_PERIOD, ph < 4 ? t_set[ph] : 48'($urandom_range(1, 65535)));
      write_reg(REG_STEP_RATE, ph < 4 ? t_set[3 - ph] : 48'($urandom_range(1, 65535)));
      repeat (160) send_tick(random_tick());
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_GAINS_PITCH, 48'd10944812);
    @(negedge clk_i);
    hold_cycles = 400;
    repeat (20) send_tick(random_tick());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    gains[0] = 48'd1573164;
    gains[1] = 48'd10944812;
    gains[2] = 48'd10944812;
    loop_on = 1'b1;
    trim_val = 8'd0;
    dt_q16 = 16'd655;
    rate_hz = 16'd100;
    for (int i = 0; i < 3; i++) begin
      integ[i] = 0;
      integ_prev[i] = 0;
      err_prev[i] = 0;
      drive_last[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_yaw_saturation();
    test_zero_step();
    test_disable();
    test_backpressure();
    test_random_phases();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (drive_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/tap_pkg.sv
sv/tap_if.sv
sv/three_axis_attitude_pid.sv
bench/tb_three_axis_attitude_pid.sv
